[sv/dpb_pkg.sv]
package dpb_pkg;

  // largest frame side the counters can hold
  localparam int MAX_DIM_DEF = 4096;

  // queue between front and back, and result queue (powers of two)
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 8;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_DEPTH_LIMIT   = 3'd2,
    REG_SCALE_RECIP   = 3'd3,
    REG_CENTER_X      = 3'd4,
    REG_CENTER_Y      = 3'd5,
    REG_FOCAL_X_RECIP = 3'd6,
    REG_FOCAL_Y_RECIP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [15:0] depth_limit;
    logic [23:0] scale_recip;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] focal_x_recip;
    logic [23:0] focal_y_recip;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:   13'd640,
    frame_height:  13'd480,
    depth_limit:   16'd5000,
    scale_recip:   24'd16777,
    center_x:      16'd5112,
    center_y:      16'd3832,
    focal_x_recip: 24'd31957,
    focal_y_recip: 24'd31957
  };

  // one finished point as it sits in the result queue
  typedef struct packed {
    logic        point_valid;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_last;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

[sv/dpb_queue.sv]
module dpb_queue
  import dpb_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [W-1:0]             wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [W-1:0]             rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (fill == (AW+1)'(DEPTH));
  assign empty   = (fill == '0);
  assign count   = fill;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[sv/dpb_front.sv]
module dpb_front
  import dpb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int ITEM_W  = 42 + 2 * $clog2(MAX_DIM)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              push,
  input  logic [15:0]       depth_raw,
  input  logic [7:0]        blue,
  input  logic [7:0]        green,
  input  logic [7:0]        red,
  input  logic              q_full,
  output logic              q_push,
  output logic [ITEM_W-1:0] q_data
);

  localparam int CW = $clog2(MAX_DIM);
  // wide enough for the size registers and for MAX_DIM itself
  localparam int EW = ($clog2(MAX_DIM + 1) > 13) ? $clog2(MAX_DIM + 1) : 13;

  typedef struct packed {
    logic          point;
    logic          last;
    logic [15:0]   depth;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [7:0]    blue;
    logic [7:0]    green;
    logic [7:0]    red;
  } item_t;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] h_eff;
  logic          row_end;
  logic          frame_end;
  item_t         item;

  // clamp size registers to 1..MAX_DIM
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(cfg.frame_width) > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = EW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = EW'(1);
    end else if (EW'(cfg.frame_height) > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = EW'(cfg.frame_height);
    end
  end

  assign row_end   = (EW'(column_count) + EW'(1)) >= w_eff;
  assign frame_end = row_end && ((EW'(row_count) + EW'(1)) >= h_eff);

  always_comb begin
    item.point = (depth_raw != '0) && (depth_raw < cfg.depth_limit);
    item.last  = frame_end;
    item.depth = depth_raw;
    item.col   = column_count;
    item.row   = row_count;
    item.blue  = blue;
    item.green = green;
    item.red   = red;
  end

  assign q_push = push && !q_full;
  assign q_data = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : CW'(row_count + 1'b1);
      end else begin
        column_count <= CW'(column_count + 1'b1);
      end
    end
  end

endmodule

[sv/dpb_back.sv]
module dpb_back
  import dpb_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF,
  parameter int ITEM_W    = 42 + 2 * $clog2(MAX_DIM)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_empty,
  input  logic [ITEM_W-1:0]          q_data,
  output logic                       q_pop,
  input  logic [$clog2(OUT_DEPTH):0] out_count,
  output logic                       res_push,
  output res_t                       res_data
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int PW   = (CW + 4 > 16) ? CW + 4 : 16;   // Q.4 pixel offset
  localparam int MW   = 28 + PW;                       // rounded axis magnitude
  localparam int CNTW = $clog2(OUT_DEPTH) + 2;

  typedef struct packed {
    logic          point;
    logic          last;
    logic [15:0]   depth;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [7:0]    blue;
    logic [7:0]    green;
    logic [7:0]    red;
  } item_t;

  typedef struct packed {
    logic       point;
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } side_t;

  item_t item;
  logic  issue;

  // stage 1: depth scale and pixel offsets
  logic [39:0]   z_prod;
  logic [32:0]   z_round;
  logic [31:0]   pz_next;
  logic [PW-1:0] pq_x, pq_y, cx, cy;
  logic          negx_next, negy_next;
  logic [PW-1:0] diffx_next, diffy_next;
  side_t         side_next;

  logic          s1_valid;
  logic [31:0]   s1_pz;
  logic          s1_negx, s1_negy;
  logic [PW-1:0] s1_diffx, s1_diffy;
  side_t         s1_side;

  // stage 2: z over focal length
  logic [55:0]   zx_sum, zy_sum;
  logic          s2_valid;
  logic [31:0]   s2_pz, s2_zrx, s2_zry;
  logic          s2_negx, s2_negy;
  logic [PW-1:0] s2_diffx, s2_diffy;
  side_t         s2_side;

  // stage 3: offset times z/f
  logic [31+PW:0] mx_sum, my_sum;
  logic           s3_valid;
  logic [31:0]    s3_pz;
  logic [MW-1:0]  s3_magx, s3_magy;
  logic           s3_negx, s3_negy;
  side_t          s3_side;

  logic [CNTW-1:0] pending;

  function automatic logic [31:0] sat_axis(input logic [MW-1:0] mag, input logic neg);
    logic [MW-1:0] lim;
    begin
      if (neg) begin
        lim = (mag > MW'(64'h8000_0000)) ? MW'(64'h8000_0000) : mag;
        sat_axis = 32'(32'd0 - lim[31:0]);
      end else begin
        sat_axis = (mag > MW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
      end
    end
  endfunction

  assign item = q_data;

  // credit: every item in flight has a seat in the result queue
  assign pending = CNTW'(out_count) + CNTW'(s1_valid) + CNTW'(s2_valid) + CNTW'(s3_valid);
  assign issue   = !q_empty && (pending < CNTW'(OUT_DEPTH));
  assign q_pop   = issue;

  always_comb begin
    z_prod  = 40'(item.depth) * 40'(cfg.scale_recip);
    z_round = 33'((z_prod + 40'd128) >> 8);
    pz_next = z_round[32] ? 32'hFFFF_FFFF : z_round[31:0];
    if (!item.point) begin
      pz_next = '0;   // zero z forces zero x and y downstream
    end
    pq_x       = PW'({item.col, 4'b0000});
    pq_y       = PW'({item.row, 4'b0000});
    cx         = PW'(cfg.center_x);
    cy         = PW'(cfg.center_y);
    negx_next  = pq_x < cx;
    negy_next  = pq_y < cy;
    diffx_next = negx_next ? PW'(cx - pq_x) : PW'(pq_x - cx);
    diffy_next = negy_next ? PW'(cy - pq_y) : PW'(pq_y - cy);
    side_next.point = item.point;
    side_next.last  = item.last;
    side_next.blue  = item.blue;
    side_next.green = item.green;
    side_next.red   = item.red;
  end

  assign zx_sum = 56'(s1_pz) * 56'(cfg.focal_x_recip) + 56'h80_0000;
  assign zy_sum = 56'(s1_pz) * 56'(cfg.focal_y_recip) + 56'h80_0000;

  assign mx_sum = (32+PW)'(s2_zrx) * (32+PW)'(s2_diffx) + (32+PW)'(8);
  assign my_sum = (32+PW)'(s2_zry) * (32+PW)'(s2_diffy) + (32+PW)'(8);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pz    <= pz_next;
    s1_negx  <= negx_next;
    s1_negy  <= negy_next;
    s1_diffx <= diffx_next;
    s1_diffy <= diffy_next;
    s1_side  <= side_next;

    s2_pz    <= s1_pz;
    s2_zrx   <= zx_sum[55:24];
    s2_zry   <= zy_sum[55:24];
    s2_negx  <= s1_negx;
    s2_negy  <= s1_negy;
    s2_diffx <= s1_diffx;
    s2_diffy <= s1_diffy;
    s2_side  <= s1_side;

    s3_pz    <= s2_pz;
    s3_magx  <= mx_sum[31+PW:4];
    s3_magy  <= my_sum[31+PW:4];
    s3_negx  <= s2_negx;
    s3_negy  <= s2_negy;
    s3_side  <= s2_side;
  end

  assign res_push = s3_valid;

  always_comb begin
    res_data.point_valid = s3_side.point;
    res_data.pos_x       = sat_axis(s3_magx, s3_negx);
    res_data.pos_y       = sat_axis(s3_magy, s3_negy);
    res_data.pos_z       = s3_pz;
    res_data.blue        = s3_side.blue;
    res_data.green       = s3_side.green;
    res_data.red         = s3_side.red;
    res_data.frame_last  = s3_side.last;
  end

endmodule

[sv/depth_pixel_backprojection_top.sv]
// Depth pixel back-projection. Pixels enter in raster order, one depth sample and
// its blue, green and red bytes per item, and each gives exactly one point item:
// z = d*scale_recip, x = (col-cx)*z*fx_recip, y = (row-cy)*z*fy_recip, all as
// Q16.16 with round-half-away-from-zero and saturation; depth zero or at/above
// depth_limit gives point_valid low with zero coordinates, colour and frame_last
// still given. Sustained rate is one item per clock while results are popped as
// they arrive. An accepted pixel is written straight into a small queue; the back
// end is a three-stage multiply pipeline (depth scale, focal reciprocal, pixel
// offset) that only takes an item when the result queue has a seat for it; results
// leave in order. Row and column counters live in the front end and reset
// to the top-left pixel. Registers are written through cfg_write/cfg_index/
// cfg_data with no wait and should only be changed while the block is idle.
// No clearing pass is needed after reset.
module depth_pixel_backprojection_top
  import dpb_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,

  // pixel input, queue style
  input  logic                  push,
  output logic                  full,
  input  logic [15:0]           depth_raw,
  input  logic [7:0]            blue,
  input  logic [7:0]            green,
  input  logic [7:0]            red,

  // point output, queue style
  output logic                  empty,
  input  logic                  pop,
  output logic                  point_valid,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_y,
  output logic [31:0]           pos_z,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic                  frame_last,

  // register writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(MAX_DIM);
  localparam int ITEM_W = 42 + 2 * CW;

  cfg_t                       cfg;
  logic                       mid_push;
  logic [ITEM_W-1:0]          mid_wdata;
  logic                       mid_full;
  logic                       mid_pop;
  logic [ITEM_W-1:0]          mid_rdata;
  logic                       mid_empty;
  logic [$clog2(MID_DEPTH):0] mid_count;
  logic                       res_push;
  res_t                       res_wdata;
  logic                       res_full;
  logic [RES_W-1:0]           res_rdata;
  res_t                       res;
  logic [$clog2(OUT_DEPTH):0] res_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[12:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[12:0];
        REG_DEPTH_LIMIT:   cfg.depth_limit   <= cfg_data[15:0];
        REG_SCALE_RECIP:   cfg.scale_recip   <= cfg_data[23:0];
        REG_CENTER_X:      cfg.center_x      <= cfg_data[15:0];
        REG_CENTER_Y:      cfg.center_y      <= cfg_data[15:0];
        REG_FOCAL_X_RECIP: cfg.focal_x_recip <= cfg_data[23:0];
        REG_FOCAL_Y_RECIP: cfg.focal_y_recip <= cfg_data[23:0];
      endcase
    end
  end

  // input side: raster counters and validity check
  dpb_front #(
    .MAX_DIM (MAX_DIM),
    .ITEM_W  (ITEM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .depth_raw (depth_raw),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .q_full    (mid_full),
    .q_push    (mid_push),
    .q_data    (mid_wdata)
  );

  // full is the queue between front and back
  assign full = mid_full;

  dpb_queue #(
    .W     (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // arithmetic side: multiply pipeline with result-queue credit
  dpb_back #(
    .MAX_DIM   (MAX_DIM),
    .OUT_DEPTH (OUT_DEPTH),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (mid_empty),
    .q_data    (mid_rdata),
    .q_pop     (mid_pop),
    .out_count (res_count),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  // result queue; credit in the back end keeps it from overflowing
  dpb_queue #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign res = res_rdata;

  // oldest waiting point on the output ports
  assign point_valid = res.point_valid && !(res_full && mid_count[0] && 1'b0);
  assign pos_x       = res.pos_x;
  assign pos_y       = res.pos_y;
  assign pos_z       = res.pos_z;
  assign out_blue    = res.blue;
  assign out_green   = res.green;
  assign out_red     = res.red;
  assign frame_last  = res.frame_last;

endmodule
